// File: rtl/fet_pkg.sv
package fet_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] OP_RECORD  = 2'd0;
  localparam logic [1:0] OP_TAKE    = 2'd1;
  localparam logic [1:0] OP_DISCARD = 2'd2;

  localparam logic [1:0] ST_SUCCESS  = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;
  localparam logic [1:0] ST_AMBIG    = 2'd3;

  typedef struct packed {
    logic [15:0] dest_network;
    logic [15:0] dest_node;
    logic [15:0] hop_network;
    logic [15:0] hop_node;
    logic [15:0] up_network;
    logic [15:0] up_node;
  } rec_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/fet_ctrl.sv
module fet_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fet_pkg::stat_t stat,
  output fet_pkg::cmd_t  cmd
);
  import fet_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // wait until the output register can take the result
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/fet_dpath.sv
module fet_dpath (
  input  logic          clk,
  input  logic          rst,
  input  fet_pkg::cmd_t  cmd,
  output fet_pkg::stat_t stat,
  input  logic [1:0]    operation,
  input  logic [15:0]   dest_network,
  input  logic [15:0]   dest_node,
  input  logic [15:0]   hop_network,
  input  logic [15:0]   hop_node,
  input  logic [15:0]   up_network,
  input  logic [15:0]   up_node,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic [15:0]   found_up_network,
  output logic [15:0]   found_up_node
);
  import fet_pkg::*;

  rec_t             recs [SLOTS];
  logic [SLOTS-1:0] valid;

  logic [1:0]       op;
  rec_t             query;
  logic [CNT_W-1:0] cnt;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             dup;
  logic             exact_found;
  logic [IDX_W-1:0] exact_idx;
  logic             first_found;
  logic [IDX_W-1:0] first_idx;
  logic [31:0]      first_up;
  logic             conflict;

  logic [IDX_W-1:0] idx;
  rec_t             cur;
  logic             cur_valid;
  logic             path_hit;
  logic             full_hit;

  assign idx       = cnt[IDX_W-1:0];
  assign cur       = recs[idx];
  assign cur_valid = valid[idx];
  assign path_hit  = cur_valid &&
                     cur.dest_network == query.dest_network &&
                     cur.dest_node    == query.dest_node &&
                     cur.hop_network  == query.hop_network &&
                     cur.hop_node     == query.hop_node;
  assign full_hit  = path_hit && cur.up_network == query.up_network &&
                     cur.up_node == query.up_node;

  assign stat.scan_last = (cnt == CNT_W'(SLOTS - 1));
  assign stat.out_free  = !out_valid || out_ready;

  // query latch and scan
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      free_found  <= 1'b0;
      dup         <= 1'b0;
      exact_found <= 1'b0;
      first_found <= 1'b0;
      conflict    <= 1'b0;
    end else if (cmd.load) begin
      op          <= operation;
      query       <= '{dest_network, dest_node, hop_network, hop_node, up_network, up_node};
      cnt         <= '0;
      free_found  <= 1'b0;
      dup         <= 1'b0;
      exact_found <= 1'b0;
      first_found <= 1'b0;
      conflict    <= 1'b0;
    end else if (cmd.step) begin
      cnt <= cnt + CNT_W'(1);
      if (!cur_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (full_hit) begin
        dup <= 1'b1;
        if (!exact_found) begin
          exact_found <= 1'b1;
          exact_idx   <= idx;
        end
      end
      if (path_hit) begin
        if (!first_found) begin
          first_found <= 1'b1;
          first_idx   <= idx;
          first_up    <= {cur.up_network, cur.up_node};
        end else if ({cur.up_network, cur.up_node} != first_up) begin
          conflict <= 1'b1;
        end
      end
    end
  end

  // table update and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (op == OP_TAKE && first_found && !conflict) begin
          found_up_network <= first_up[31:16];
          found_up_node    <= first_up[15:0];
        end else begin
          found_up_network <= '0;
          found_up_node    <= '0;
        end
        case (op)
          OP_RECORD: begin
            if (dup) begin
              status <= ST_SUCCESS;
            end else if (free_found) begin
              recs[free_idx]  <= query;
              valid[free_idx] <= 1'b1;
              status          <= ST_SUCCESS;
            end else begin
              status <= ST_FULL;
            end
          end
          OP_TAKE: begin
            if (!first_found) begin
              status <= ST_NO_MATCH;
            end else if (conflict) begin
              status <= ST_AMBIG;
            end else begin
              valid[first_idx] <= 1'b0;
              status           <= ST_SUCCESS;
            end
          end
          OP_DISCARD: begin
            if (exact_found) begin
              valid[exact_idx] <= 1'b0;
              status           <= ST_SUCCESS;
            end else begin
              status <= ST_NO_MATCH;
            end
          end
          default: begin
            status <= ST_NO_MATCH;
          end
        endcase
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/forward_evidence_table.sv
// a result is valid once its word is latched, every slot has been scanned in turn
// and the result has been committed into the output register, which waits until that register is free
// the scan checks one slot per cycle; the next word is taken while the previous result
// waits in the output register, but a new commit stalls until that result is taken
// reset: synchronous, clears all slot valid bits, the controller and the output valid
module forward_evidence_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] dest_network,
  input  logic [15:0] dest_node,
  input  logic [15:0] hop_network,
  input  logic [15:0] hop_node,
  input  logic [15:0] up_network,
  input  logic [15:0] up_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] found_up_network,
  output logic [15:0] found_up_node
);
  import fet_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fet_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (operation),
    .dest_network     (dest_network),
    .dest_node        (dest_node),
    .hop_network      (hop_network),
    .hop_node         (hop_node),
    .up_network       (up_network),
    .up_node          (up_node),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .found_up_network (found_up_network),
    .found_up_node    (found_up_node)
  );

endmodule
